[rtl/core/aavr_pkg.sv]
// Shared constants, widths and the CORDIC arctangent table for the axis-angle rotator.
package aavr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int VEC_WIDTH_DEF     = 16;
    localparam int ATAN_COUNT        = 24;

    // CORDIC x/y width (Q2.30 with headroom) and phase accumulator width.
    localparam int XW  = 34;
    localparam int ZW  = 33;
    localparam int AXW = 16;
    // Quaternion component, doubled product and matrix entry widths.
    localparam int QW  = 34;
    localparam int TPW = 33;
    localparam int MW  = 36;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sd652032874);
    localparam logic signed [MW-1:0] MAT_ONE     = MW'(64'sd16777216);

    // Arctangent of 2^-i in units of 2^-32 turn, rounded.
    function automatic logic signed [ZW-1:0] atan_turn(input int unsigned idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = ZW'(64'sd536870912);
            1:  v = ZW'(64'sd316933406);
            2:  v = ZW'(64'sd167458907);
            3:  v = ZW'(64'sd85004756);
            4:  v = ZW'(64'sd42667331);
            5:  v = ZW'(64'sd21354465);
            6:  v = ZW'(64'sd10679838);
            7:  v = ZW'(64'sd5340245);
            8:  v = ZW'(64'sd2670163);
            9:  v = ZW'(64'sd1335087);
            10: v = ZW'(64'sd667544);
            11: v = ZW'(64'sd333772);
            12: v = ZW'(64'sd166886);
            13: v = ZW'(64'sd83443);
            14: v = ZW'(64'sd41722);
            15: v = ZW'(64'sd20861);
            16: v = ZW'(64'sd10430);
            17: v = ZW'(64'sd5215);
            18: v = ZW'(64'sd2608);
            19: v = ZW'(64'sd1304);
            20: v = ZW'(64'sd652);
            21: v = ZW'(64'sd326);
            22: v = ZW'(64'sd163);
            23: v = ZW'(64'sd81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/aavr_cordic.sv]
// Pipelined rotation-mode CORDIC producing sin and cos of the half angle.
module aavr_cordic #(
    parameter int CORDIC_STAGES = aavr_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W        = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [15:0]                    i_angle,
    input  logic [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    output logic                           o_second,
    output logic signed [aavr_pkg::XW-1:0] o_x,
    output logic signed [aavr_pkg::XW-1:0] o_y,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int NS = (CORDIC_STAGES < aavr_pkg::ATAN_COUNT) ?
                        CORDIC_STAGES : aavr_pkg::ATAN_COUNT;

    logic                           r_v      [0:NS];
    logic                           r_second [0:NS];
    logic signed [aavr_pkg::XW-1:0] r_x      [0:NS];
    logic signed [aavr_pkg::XW-1:0] r_y      [0:NS];
    logic signed [aavr_pkg::ZW-1:0] r_z      [0:NS];
    logic [SIDE_W-1:0]              r_side   [0:NS];

    logic        n_second;
    logic [16:0] n_phase;

    // Second-half angles fold onto the first half; the cosine sign is fixed later.
    always_comb begin
        n_second = i_angle[15];
        n_phase  = n_second ? (17'd65536 - {1'b0, i_angle}) : {1'b0, i_angle};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_second[0] <= n_second;
            r_x[0]      <= aavr_pkg::CORDIC_GAIN;
            r_y[0]      <= '0;
            r_z[0]      <= $signed({1'b0, n_phase, 15'd0});
            r_side[0]   <= i_side;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_second[g+1] <= r_second[g];
                r_side[g+1]   <= r_side[g];
                if (!r_z[g][aavr_pkg::ZW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - aavr_pkg::atan_turn(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + aavr_pkg::atan_turn(g);
                end
            end
        end
    end

    assign o_valid  = r_v[NS];
    assign o_second = r_second[NS];
    assign o_x      = r_x[NS];
    assign o_y      = r_y[NS];
    assign o_side   = r_side[NS];

endmodule

[rtl/core/aavr_quat_mat.sv]
// Quaternion formation and rotation matrix build over three register stages.
module aavr_quat_mat #(
    parameter int VW = aavr_pkg::VEC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic                            i_second,
    input  logic signed [aavr_pkg::XW-1:0]  i_x,
    input  logic signed [aavr_pkg::XW-1:0]  i_y,
    input  logic signed [aavr_pkg::AXW-1:0] i_axis [3],
    input  logic signed [VW-1:0]            i_vec  [3],
    output logic                            o_valid,
    output logic signed [aavr_pkg::MW-1:0]  o_m    [9],
    output logic signed [VW-1:0]            o_vec  [3]
);

    localparam int QPW = aavr_pkg::XW + aavr_pkg::AXW;
    localparam int PPW = 2 * aavr_pkg::QW;

    logic                           r_v   [3];
    logic signed [VW-1:0]           r_vec [3][3];
    logic signed [aavr_pkg::QW-1:0] r_q   [4];
    logic signed [aavr_pkg::TPW-1:0] r_p  [9];
    logic signed [aavr_pkg::MW-1:0] r_m   [9];

    logic signed [QPW-1:0]          n_qp  [3];
    logic signed [PPW-1:0]          n_pp  [9];
    logic signed [aavr_pkg::QW-1:0] pa    [9];
    logic signed [aavr_pkg::QW-1:0] pb    [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_qp[k] = (QPW'(i_y) * QPW'(i_axis[k]) + QPW'(8192)) >>> 14;
        end
    end

    // Product order: q1q1 q2q2 q3q3 q1q2 q0q3 q0q2 q1q3 q2q3 q0q1.
    always_comb begin
        pa[0] = r_q[1]; pb[0] = r_q[1];
        pa[1] = r_q[2]; pb[1] = r_q[2];
        pa[2] = r_q[3]; pb[2] = r_q[3];
        pa[3] = r_q[1]; pb[3] = r_q[2];
        pa[4] = r_q[0]; pb[4] = r_q[3];
        pa[5] = r_q[0]; pb[5] = r_q[2];
        pa[6] = r_q[1]; pb[6] = r_q[3];
        pa[7] = r_q[2]; pb[7] = r_q[3];
        pa[8] = r_q[0]; pb[8] = r_q[1];
        for (int k = 0; k < 9; k++) begin
            n_pp[k] = (PPW'(pa[k]) * PPW'(pb[k]) + (PPW'(1) <<< 34)) >>> 35;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_second ? -aavr_pkg::QW'(i_x) : aavr_pkg::QW'(i_x);
            for (int k = 0; k < 3; k++) begin
                r_q[k+1]    <= n_qp[k][aavr_pkg::QW-1:0];
                r_vec[0][k] <= i_vec[k];
                r_vec[1][k] <= r_vec[0][k];
                r_vec[2][k] <= r_vec[1][k];
            end
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= n_pp[k][aavr_pkg::TPW-1:0];
            end
            r_m[0] <= aavr_pkg::MAT_ONE - aavr_pkg::MW'(r_p[1]) - aavr_pkg::MW'(r_p[2]);
            r_m[1] <= aavr_pkg::MW'(r_p[3]) - aavr_pkg::MW'(r_p[4]);
            r_m[2] <= aavr_pkg::MW'(r_p[5]) + aavr_pkg::MW'(r_p[6]);
            r_m[3] <= aavr_pkg::MW'(r_p[3]) + aavr_pkg::MW'(r_p[4]);
            r_m[4] <= aavr_pkg::MAT_ONE - aavr_pkg::MW'(r_p[0]) - aavr_pkg::MW'(r_p[2]);
            r_m[5] <= aavr_pkg::MW'(r_p[7]) - aavr_pkg::MW'(r_p[8]);
            r_m[6] <= aavr_pkg::MW'(r_p[6]) - aavr_pkg::MW'(r_p[5]);
            r_m[7] <= aavr_pkg::MW'(r_p[8]) + aavr_pkg::MW'(r_p[7]);
            r_m[8] <= aavr_pkg::MAT_ONE - aavr_pkg::MW'(r_p[0]) - aavr_pkg::MW'(r_p[1]);
        end
    end

    assign o_valid = r_v[2];
    assign o_m     = r_m;
    assign o_vec   = r_vec[2];

endmodule

[rtl/core/aavr_mat_vec.sv]
// Matrix-vector product with rounding and saturation, two register stages.
module aavr_mat_vec #(
    parameter int VW = aavr_pkg::VEC_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [aavr_pkg::MW-1:0] i_m   [9],
    input  logic signed [VW-1:0]           i_vec [3],
    output logic                           o_valid,
    output logic signed [VW:0]             o_rot [3]
);

    localparam int PW = aavr_pkg::MW + VW;
    localparam int AW = PW + 2;
    localparam int OW = VW + 1;

    localparam logic signed [AW-1:0] OUT_MAX = AW'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] OUT_MIN = -OUT_MAX - AW'(1);

    logic                  r_v   [2];
    logic signed [PW-1:0]  r_p   [9];
    logic signed [OW-1:0]  r_rot [3];
    logic signed [AW-1:0]  n_acc [3];
    logic signed [OW-1:0]  n_rot [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = (AW'(r_p[3*i]) + AW'(r_p[3*i+1]) + AW'(r_p[3*i+2])
                        + (AW'(1) <<< 23)) >>> 24;
            if (n_acc[i] > OUT_MAX) begin
                n_rot[i] = OUT_MAX[OW-1:0];
            end else if (n_acc[i] < OUT_MIN) begin
                n_rot[i] = OUT_MIN[OW-1:0];
            end else begin
                n_rot[i] = n_acc[i][OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p[3*i+k] <= PW'(i_m[3*i+k]) * PW'(i_vec[k]);
                end
                r_rot[i] <= n_rot[i];
            end
        end
    end

    assign o_valid = r_v[1];
    assign o_rot   = r_rot;

endmodule

[rtl/core/axis_angle_vector_rotation.sv]
// Top level of the axis-angle quaternion vector rotator.
//
// Each transaction carries an angle (65536 units to a full turn), a unit axis in Q1.14 and an
// integer vector; the block returns the vector rotated about the axis, rounded and saturated
// to VEC_WIDTH+1 bits. One transaction is accepted every clock cycle while o_stall is low;
// results leave in order through the CORDIC pipeline (CORDIC_STAGES capped at 24), which has
// an input register and one register per iteration, followed by quaternion, doubled-product,
// matrix, multiply and accumulate/saturate stages. The whole pipeline advances together and
// freezes while a finished result waits on o_valid with i_stall high, so o_stall is high
// exactly then. There is no state between transactions.
module axis_angle_vector_rotation #(
    parameter int CORDIC_STAGES = aavr_pkg::CORDIC_STAGES_DEF,
    parameter int VEC_WIDTH     = aavr_pkg::VEC_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [15:0]          i_angle,
    input  logic signed [15:0]   i_axis_x,
    input  logic signed [15:0]   i_axis_y,
    input  logic signed [15:0]   i_axis_z,
    input  logic signed [VEC_WIDTH-1:0] i_vec_x,
    input  logic signed [VEC_WIDTH-1:0] i_vec_y,
    input  logic signed [VEC_WIDTH-1:0] i_vec_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [VEC_WIDTH:0] o_rot_x,
    output logic signed [VEC_WIDTH:0] o_rot_y,
    output logic signed [VEC_WIDTH:0] o_rot_z
);

    localparam int VW     = VEC_WIDTH;
    localparam int SIDE_W = 3 * aavr_pkg::AXW + 3 * VW;

    logic                            en;
    logic [SIDE_W-1:0]               side_in;
    logic [SIDE_W-1:0]               side_out;
    logic                            c_valid;
    logic                            c_second;
    logic signed [aavr_pkg::XW-1:0]  c_x;
    logic signed [aavr_pkg::XW-1:0]  c_y;
    logic signed [aavr_pkg::AXW-1:0] axis [3];
    logic signed [VW-1:0]            vec  [3];
    logic                            m_valid;
    logic signed [aavr_pkg::MW-1:0]  m    [9];
    logic signed [VW-1:0]            m_vec [3];
    logic signed [VW:0]              rot  [3];

    // The pipeline moves only when the output slot is empty or being taken.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Axis and vector ride beside the CORDIC pipeline as one packed word.
    assign side_in = {i_axis_x, i_axis_y, i_axis_z, i_vec_x, i_vec_y, i_vec_z};

    always_comb begin
        axis[0] = side_out[SIDE_W-1 -: aavr_pkg::AXW];
        axis[1] = side_out[SIDE_W-1-aavr_pkg::AXW -: aavr_pkg::AXW];
        axis[2] = side_out[SIDE_W-1-2*aavr_pkg::AXW -: aavr_pkg::AXW];
        vec[0]  = side_out[3*VW-1 -: VW];
        vec[1]  = side_out[2*VW-1 -: VW];
        vec[2]  = side_out[VW-1 -: VW];
    end

    aavr_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .SIDE_W       (SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .i_side  (side_in),
        .o_valid (c_valid),
        .o_second(c_second),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_side  (side_out)
    );

    aavr_quat_mat #(
        .VW(VW)
    ) u_quat_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_second(c_second),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_axis  (axis),
        .i_vec   (vec),
        .o_valid (m_valid),
        .o_m     (m),
        .o_vec   (m_vec)
    );

    aavr_mat_vec #(
        .VW(VW)
    ) u_mat_vec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(m_valid),
        .i_m    (m),
        .i_vec  (m_vec),
        .o_valid(o_valid),
        .o_rot  (rot)
    );

    assign o_rot_x = rot[0];
    assign o_rot_y = rot[1];
    assign o_rot_z = rot[2];

    // The input side stalls only because a result is being held back.
    a_stall_cause: assert property (@(posedge i_clk) o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A held result is still there in the next cycle.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("held result dropped");

    // Reset empties the output slot.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // A frozen pipeline keeps the last stage of the matrix path intact.
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(m_valid))
        else $error("pipeline moved while stalled");

endmodule
